/* rtl/i2cbm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and constants of the I2C bit-level master: command codes,
// engine state, request and result records.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_SEND  = 3'd3,
      OP_RECV  = 3'd4,
      OP_SACK  = 3'd5,
      OP_RACK  = 3'd6,
      OP_WAIT  = 3'd7
   } op_type;

   localparam logic [7:0] ACK_LIMIT_RESET = 8'd250;
   localparam logic [2:0] LAST_BIT        = 3'd7;
   // wait ack: read step, low-read release step, first step of the stop tail
   localparam logic [2:0] WAIT_READ_STEP  = 3'd2;
   localparam logic [2:0] WAIT_ACK_STEP   = 3'd3;
   localparam logic [2:0] WAIT_STOP_STEP  = 3'd4;

   typedef struct packed {
      op_type      cmd;
      logic [2:0]  step;
      logic [2:0]  bit_idx;
      logic [7:0]  shift;
      logic [7:0]  wait_count;
      logic        scl;
      logic        sda;
      logic        stop_to;
      logic [7:0]  rx_byte;
      logic        ack_flag;
   } state_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  tx_byte;
      logic        ack_bit;
      logic        sda_in;
   } item_type;

   typedef struct packed {
      logic        scl_out;
      logic        sda_out;
      logic        busy_res;
      logic        done_res;
      logic [7:0]  rx_data;
      logic        ack_seen;
      logic        timed_out;
   } result_type;

endpackage

/* rtl/i2cbm_step.sv */
// ----------------------------------------------------------------------------
// i2cbm_step
// One pin-step tick of the engine: command launch, one pin action of the
// active command, next engine state and the tick's result.
// ----------------------------------------------------------------------------
module i2cbm_step (
   input  i2cbm_pkg::state_type  cur_state,
   input  i2cbm_pkg::item_type   item,
   input  logic [7:0]            ack_limit,
   output i2cbm_pkg::state_type  nxt_state,
   output i2cbm_pkg::result_type result
);

   i2cbm_pkg::state_type st;
   logic                 fin;
   logic                 tout;
   logic                 hold_step;

   always_comb begin
      st        = cur_state;
      fin       = 1'b0;
      tout      = 1'b0;
      hold_step = 1'b0;

      // launch a command only from idle
      if (st.cmd == i2cbm_pkg::OP_NONE && item.op != i2cbm_pkg::OP_NONE) begin
         st.cmd        = i2cbm_pkg::op_type'(item.op);
         st.step       = 3'd0;
         st.bit_idx    = 3'd0;
         st.wait_count = 8'd0;
         st.stop_to    = 1'b0;
         if (item.op == i2cbm_pkg::OP_SEND) begin
            st.shift = item.tx_byte;
         end else if (item.op == i2cbm_pkg::OP_SACK) begin
            st.shift = {7'd0, item.ack_bit};
         end else begin
            st.shift = 8'd0;
         end
      end

      case (st.cmd)
         i2cbm_pkg::OP_START: begin
            case (st.step)
               3'd0:    st.sda = 1'b1;
               3'd1:    st.scl = 1'b1;
               3'd2:    st.sda = 1'b0;
               default: begin
                  st.scl = 1'b0;
                  fin    = 1'b1;
               end
            endcase
         end
         i2cbm_pkg::OP_STOP: begin
            case (st.step[1:0])
               2'd0:    st.scl = 1'b0;
               2'd1:    st.sda = 1'b0;
               2'd2:    st.scl = 1'b1;
               default: begin
                  st.sda = 1'b1;
                  fin    = 1'b1;
               end
            endcase
         end
         i2cbm_pkg::OP_SEND: begin
            if (st.step == 3'd0) begin
               st.sda = st.shift[7];
            end else if (st.step == 3'd1) begin
               st.scl = 1'b1;
            end else begin
               st.scl     = 1'b0;
               st.shift   = {st.shift[6:0], 1'b0};
               fin        = (st.bit_idx == i2cbm_pkg::LAST_BIT);
               st.bit_idx = st.bit_idx + 3'd1;
               st.step    = 3'd0;
               hold_step  = 1'b1;
            end
         end
         i2cbm_pkg::OP_RECV: begin
            if (st.step == 3'd0) begin
               st.scl = 1'b1;
            end else if (st.step == 3'd1) begin
               st.shift = {st.shift[6:0], item.sda_in};
            end else begin
               st.scl = 1'b0;
               if (st.bit_idx == i2cbm_pkg::LAST_BIT) begin
                  st.rx_byte = st.shift;
                  fin        = 1'b1;
               end
               st.bit_idx = st.bit_idx + 3'd1;
               st.step    = 3'd0;
               hold_step  = 1'b1;
            end
         end
         i2cbm_pkg::OP_SACK: begin
            case (st.step)
               3'd0:    st.scl = 1'b0;
               3'd1:    st.sda = st.shift[0];
               3'd2:    st.scl = 1'b1;
               default: begin
                  st.scl = 1'b0;
                  fin    = 1'b1;
               end
            endcase
         end
         i2cbm_pkg::OP_RACK: begin
            case (st.step)
               3'd0:    st.sda = 1'b1;
               3'd1:    st.scl = 1'b1;
               3'd2:    st.ack_flag = item.sda_in;
               default: begin
                  st.scl = 1'b0;
                  fin    = 1'b1;
               end
            endcase
         end
         i2cbm_pkg::OP_WAIT: begin
            if (st.step == 3'd0) begin
               st.sda = 1'b1;
            end else if (st.step == 3'd1) begin
               st.scl = 1'b1;
            end else if (st.step == i2cbm_pkg::WAIT_READ_STEP) begin
               // keep reading until low or the limit runs out
               st.ack_flag = item.sda_in;
               hold_step   = 1'b1;
               if (item.sda_in) begin
                  if (st.wait_count >= ack_limit) begin
                     st.stop_to = 1'b1;
                     st.step    = i2cbm_pkg::WAIT_STOP_STEP;
                  end else begin
                     st.wait_count = st.wait_count + 8'd1;
                  end
               end else begin
                  st.step = i2cbm_pkg::WAIT_ACK_STEP;
               end
            end else if (st.step == i2cbm_pkg::WAIT_ACK_STEP) begin
               st.scl = 1'b0;
               fin    = 1'b1;
            end else begin
               // stop tail after a timeout
               case (st.step[1:0])
                  2'd0:    st.scl = 1'b0;
                  2'd1:    st.sda = 1'b0;
                  2'd2:    st.scl = 1'b1;
                  default: begin
                     st.sda     = 1'b1;
                     fin        = 1'b1;
                     tout       = 1'b1;
                     st.stop_to = 1'b0;
                  end
               endcase
            end
         end
         default: hold_step = 1'b1;
      endcase

      if (st.cmd != i2cbm_pkg::OP_NONE && !hold_step) begin
         st.step = st.step + 3'd1;
      end

      if (fin) begin
         st.cmd     = i2cbm_pkg::OP_NONE;
         st.step    = 3'd0;
         st.bit_idx = 3'd0;
         st.stop_to = 1'b0;
      end
   end

   assign nxt_state        = st;
   assign result.scl_out   = st.scl;
   assign result.sda_out   = st.sda;
   assign result.busy_res  = (st.cmd != i2cbm_pkg::OP_NONE);
   assign result.done_res  = fin;
   assign result.rx_data   = st.rx_byte;
   assign result.ack_seen  = st.ack_flag;
   assign result.timed_out = tout;

endmodule

/* rtl/i2c_bit_level_master.sv */
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// Bit-level I2C master engine driven one pin-step tick per request.
// ----------------------------------------------------------------------------
// Each request is one pin-step tick and yields exactly one response carrying
// the SCL/SDA levels driven on that tick, busy/done, the last received byte,
// the last sampled acknowledge and the timeout flag. A request is registered,
// then the step logic advances the engine state and loads the response
// register when that register is free; a new request is taken every cycle
// while the response side keeps up. Commands in a request are
// ignored while a command is in progress. csr_ack_timeout_limit sets how many
// consecutive high SDA reads wait-ack tolerates before it drives a stop and
// reports a timeout; write it only while the engine is idle.
// ----------------------------------------------------------------------------
module i2c_bit_level_master (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_op,
   input  logic [7:0] req_tx_byte,
   input  logic       req_ack_bit,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_out,
   output logic       rsp_sda_out,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_rx_data,
   output logic       rsp_ack_seen,
   output logic       rsp_timed_out,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_ack_timeout_limit
);

   logic                  in_valid_ff;
   i2cbm_pkg::item_type   in_item_ff;
   logic                  out_valid_ff;
   i2cbm_pkg::result_type out_res_ff;
   i2cbm_pkg::state_type  state_ff;
   i2cbm_pkg::state_type  state_in;
   i2cbm_pkg::result_type res_in;
   logic [7:0]            limit_ff;
   logic                  advance;

   // move a request into the response register when that slot frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   i2cbm_step u_step (
      .cur_state (state_ff),
      .item      (in_item_ff),
      .ack_limit (limit_ff),
      .nxt_state (state_in),
      .result    (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= i2cbm_pkg::ACK_LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_ack_timeout_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.op      <= req_op;
         in_item_ff.tx_byte <= req_tx_byte;
         in_item_ff.ack_bit <= req_ack_bit;
         in_item_ff.sda_in  <= req_sda_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // idle, both lines released
         state_ff <= '{cmd: i2cbm_pkg::OP_NONE, scl: 1'b1, sda: 1'b1, default: '0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= res_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_scl_out   = out_res_ff.scl_out;
   assign rsp_sda_out   = out_res_ff.sda_out;
   assign rsp_busy_res  = out_res_ff.busy_res;
   assign rsp_done_res  = out_res_ff.done_res;
   assign rsp_rx_data   = out_res_ff.rx_data;
   assign rsp_ack_seen  = out_res_ff.ack_seen;
   assign rsp_timed_out = out_res_ff.timed_out;

endmodule
